// File: sv/mwwl_pkg.sv
// ----------------------------------------------------------------------------
// mwwl_pkg
// Shared constants and types for the median window weight linearizer:
// field widths, breakpoints of the weight curve and the cell link record.
// ----------------------------------------------------------------------------
package mwwl_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int WEIGHT_W = 14;

    // default window length
    localparam int WINDOW_DEF = 10;

    // breakpoints of the piecewise linear curve, in converter codes
    localparam logic [SAMPLE_W-1:0] KNEE1      = 10'd310;
    localparam logic [SAMPLE_W-1:0] KNEE2      = 10'd465;
    localparam logic [SAMPLE_W-1:0] KNEE3      = 10'd775;
    localparam logic [SAMPLE_W-1:0] LIMIT_CODE = 10'd930;

    // segment slopes and offsets of N, evaluated at 20 bits
    localparam int N_CALC_W = 20;
    localparam int N_W      = 19;
    localparam logic [N_CALC_W-1:0] SLOPE0 = 20'd40;
    localparam logic [N_CALC_W-1:0] SLOPE1 = 20'd120;
    localparam logic [N_CALC_W-1:0] OFFS1  = 20'd24800;
    localparam logic [N_CALC_W-1:0] SLOPE2 = 20'd500;
    localparam logic [N_CALC_W-1:0] OFFS2  = 20'd201500;
    localparam logic [N_CALC_W-1:0] SLOPE3 = 20'd800;
    localparam logic [N_CALC_W-1:0] OFFS3  = 20'd434000;

    // scaled numerator 16*N and its division by codes per volt
    localparam int X_W         = 23;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam logic [X_W-1:0]     CODES_PER_VOLT = 23'd310;
    localparam logic [RECIP_W-1:0] RECIP          = 24'd13854733;

    // largest weight the curve can give
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 14'd15958;

    // what one sorting cell shows its right neighbor
    typedef struct packed {
        logic                valid;
        logic                gt;
        logic [SAMPLE_W-1:0] value;
    } cell_link_t;

endpackage

// File: sv/mwwl_if.sv
// ----------------------------------------------------------------------------
// mwwl_sample_if / mwwl_result_if
// Valid/ready channels carrying sample beats in and result beats out.
// ----------------------------------------------------------------------------
interface mwwl_sample_if;
    logic                          valid;
    logic                          ready;
    logic [mwwl_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mwwl_result_if;
    logic                          valid;
    logic                          ready;
    logic [mwwl_pkg::SAMPLE_W-1:0] median_code;
    logic [mwwl_pkg::WEIGHT_W-1:0] weight_sixteenths;
    logic                          in_range;

    modport source (output valid, output median_code, output weight_sixteenths,
                    output in_range, input ready);
    modport sink   (input valid, input median_code, input weight_sixteenths,
                    input in_range, output ready);
endinterface

// File: sv/median_window_weight_linearizer.sv
// ----------------------------------------------------------------------------
// median_window_weight_linearizer
// Sorts each window of samples in a chain of insertion cells as the beats
// arrive, takes the median on the last beat and turns it into a weight.
// ----------------------------------------------------------------------------
// Throughput: one sample beat per cycle, one result per WINDOW samples.
// Result path after the window's last sample beat: median register,
//   scaling, reciprocal multiply, correction/output.
// Samples keep flowing while a result waits; the last beat of a window
//   stalls only when the median register cannot move on.
// Reset clears the fill count, the cell occupancy bits and all stage valids.
// ----------------------------------------------------------------------------
module median_window_weight_linearizer #(
    parameter int WINDOW = mwwl_pkg::WINDOW_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mwwl_sample_if.sink   samples,
    mwwl_result_if.source results
);

    localparam int SW    = mwwl_pkg::SAMPLE_W;
    localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW - 1);
    localparam mwwl_pkg::cell_link_t HEAD = '{valid: 1'b1, gt: 1'b0, value: '0};

    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic             last_beat;
    logic             accept;
    logic             s1_free;
    logic             s1_valid_reg;
    logic [SW-1:0]    s1_median_reg;
    logic [SW-1:0]    median_next;
    logic             wgt_ready;

    mwwl_pkg::cell_link_t cell_out [WINDOW];
    logic [SW-1:0]        next_val [WINDOW];

    // accept control
    assign last_beat     = fill_count_reg == LAST_CNT;
    assign s1_free       = !s1_valid_reg || wgt_ready;
    assign samples.ready = !last_beat || s1_free;
    assign accept        = samples.valid && samples.ready;

    // window fill counter
    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (accept)
        begin
            fill_count_next = last_beat ? '0 : fill_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // sorted insertion chain
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        mwwl_pkg::cell_link_t left_in;

        if (i == 0)
        begin : g_head
            assign left_in = HEAD;
        end
        else
        begin : g_body
            assign left_in = cell_out[i-1];
        end

        mwwl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (accept),
            .clear      (accept && last_beat),
            .sample     (samples.sample),
            .left       (left_in),
            .right      (cell_out[i]),
            .value_next (next_val[i])
        );
    end

    // median from the chain's next contents
    if ((WINDOW % 2) == 0)
    begin : g_even
        logic [SW:0] mid_sum;
        assign mid_sum     = {1'b0, next_val[WINDOW/2]} + {1'b0, next_val[WINDOW/2-1]};
        assign median_next = mid_sum[SW:1];
    end
    else
    begin : g_odd
        assign median_next = next_val[WINDOW/2];
    end

    // median register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= accept && last_beat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && accept && last_beat)
        begin
            s1_median_reg <= median_next;
        end
    end

    // weight pipeline and output register
    mwwl_weight u_weight (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid_reg),
        .in_ready (wgt_ready),
        .median   (s1_median_reg),
        .results  (results)
    );

endmodule

// File: sv/mwwl_cell.sv
// ----------------------------------------------------------------------------
// mwwl_cell
// One cell of the sorted insertion chain. Holds one code of the window;
// empty cells count as larger than any sample, so the chain stays sorted
// with empty cells at the high end.
// ----------------------------------------------------------------------------
module mwwl_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          clear,
    input  logic [mwwl_pkg::SAMPLE_W-1:0] sample,
    input  mwwl_pkg::cell_link_t          left,
    output mwwl_pkg::cell_link_t          right,
    output logic [mwwl_pkg::SAMPLE_W-1:0] value_next
);

    logic                          valid_reg, valid_next;
    logic [mwwl_pkg::SAMPLE_W-1:0] value_reg;
    logic                          gt;

    // this cell gives way to the new sample
    assign gt = !valid_reg || (value_reg > sample);

    assign right.valid = valid_reg;
    assign right.gt    = gt;
    assign right.value = value_reg;

    // shift up from the left neighbor, take the sample, or keep
    always_comb
    begin
        if (!gt)
        begin
            value_next = value_reg;
        end
        else if (left.gt)
        begin
            value_next = left.value;
        end
        else
        begin
            value_next = sample;
        end
    end

    // occupancy grows from the low end by one per beat
    always_comb
    begin
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (load)
        begin
            valid_next = valid_reg | left.valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
        end
    end

endmodule

// File: sv/mwwl_weight.sv
// ----------------------------------------------------------------------------
// mwwl_weight
// Three-stage pipeline from median code to weight: segment select and
// scaling, reciprocal multiply, remainder correction into the output
// register. Each stage holds its own valid so bubbles collapse.
// ----------------------------------------------------------------------------
module mwwl_weight (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mwwl_pkg::SAMPLE_W-1:0] median,
    mwwl_result_if.source                 results
);

    localparam int SW = mwwl_pkg::SAMPLE_W;
    localparam int WW = mwwl_pkg::WEIGHT_W;
    localparam int XW = mwwl_pkg::X_W;
    localparam int CW = mwwl_pkg::N_CALC_W;

    logic en2, en3, en4;

    // stage 2 registers
    logic          s2_valid_reg;
    logic [SW-1:0] s2_median_reg;
    logic          s2_range_reg;
    logic [XW-1:0] s2_x_reg;

    // stage 3 registers
    logic          s3_valid_reg;
    logic [SW-1:0] s3_median_reg;
    logic          s3_range_reg;
    logic [XW-1:0] s3_x_reg;
    logic [WW-1:0] s3_q_reg;

    // output registers
    logic          out_valid_reg;
    logic [SW-1:0] out_median_reg;
    logic          out_range_reg;
    logic [WW-1:0] out_weight_reg;

    logic                          in_range;
    logic [CW-1:0]                 m_ext;
    logic [CW-1:0]                 n_calc;
    logic [XW-1:0]                 x_next;
    logic [mwwl_pkg::PROD_W-1:0]   prod;
    logic [XW-1:0]                 rem;
    logic [WW-1:0]                 q_next;

    // stall chain from the output backwards
    assign en4      = !out_valid_reg || results.ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign in_ready = en2;

    // piecewise linear numerator, zero when out of range
    assign in_range = median < mwwl_pkg::LIMIT_CODE;
    assign m_ext    = CW'(median);

    always_comb
    begin
        if (median < mwwl_pkg::KNEE1)
        begin
            n_calc = m_ext * mwwl_pkg::SLOPE0;
        end
        else if (median < mwwl_pkg::KNEE2)
        begin
            n_calc = m_ext * mwwl_pkg::SLOPE1 - mwwl_pkg::OFFS1;
        end
        else if (median < mwwl_pkg::KNEE3)
        begin
            n_calc = m_ext * mwwl_pkg::SLOPE2 - mwwl_pkg::OFFS2;
        end
        else
        begin
            n_calc = m_ext * mwwl_pkg::SLOPE3 - mwwl_pkg::OFFS3;
        end
    end

    assign x_next = in_range ? {n_calc[mwwl_pkg::N_W-1:0], 4'b0000} : '0;

    // quotient estimate, low by at most one
    assign prod = mwwl_pkg::PROD_W'(s2_x_reg) * mwwl_pkg::PROD_W'(mwwl_pkg::RECIP);

    // remainder check fixes the estimate
    assign rem    = s3_x_reg - XW'(s3_q_reg) * mwwl_pkg::CODES_PER_VOLT;
    assign q_next = (rem >= mwwl_pkg::CODES_PER_VOLT) ? s3_q_reg + WW'(1) : s3_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                s2_valid_reg <= in_valid;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_median_reg <= median;
            s2_range_reg  <= in_range;
            s2_x_reg      <= x_next;
        end
        if (en3)
        begin
            s3_median_reg <= s2_median_reg;
            s3_range_reg  <= s2_range_reg;
            s3_x_reg      <= s2_x_reg;
            s3_q_reg      <= prod[mwwl_pkg::RECIP_SHIFT +: WW];
        end
        if (en4)
        begin
            out_median_reg <= s3_median_reg;
            out_range_reg  <= s3_range_reg;
            out_weight_reg <= q_next;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.median_code       = out_median_reg;
    assign results.weight_sixteenths = out_weight_reg;
    assign results.in_range          = out_range_reg;

endmodule

// File: sv/mwwl_checker.sv
// ----------------------------------------------------------------------------
// mwwl_checker
// Port-level checks on the result channel of the linearizer, attached by
// bind to the top level.
// ----------------------------------------------------------------------------
module mwwl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mwwl_pkg::SAMPLE_W-1:0] median_code,
    input logic [mwwl_pkg::WEIGHT_W-1:0] weight_sixteenths,
    input logic                          in_range
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median_code)
            && $stable(weight_sixteenths) && $stable(in_range))
        else $error("result beat changed while stalled");

    // range flag follows the median
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_range == (median_code < mwwl_pkg::LIMIT_CODE))
        else $error("in_range disagrees with median_code");

    // out of range gives zero weight
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> weight_sixteenths == '0)
        else $error("nonzero weight while out of range");

    // weight never passes the top of the curve
    a_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight_sixteenths <= mwwl_pkg::WEIGHT_MAX)
        else $error("weight above curve maximum");

endmodule

bind median_window_weight_linearizer mwwl_checker u_mwwl_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (results.valid),
    .out_ready         (results.ready),
    .median_code       (results.median_code),
    .weight_sixteenths (results.weight_sixteenths),
    .in_range          (results.in_range)
);
